>>> src/qslp_pkg.sv
// Shared constants, types and the arctangent table for the slerp pipeline.
package qslp_pkg;

   localparam int FRAC_BITS    = 15;
   localparam int QI           = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int XW           = 34;
   localparam int ZW           = 33;
   localparam int MW           = 50;
   localparam int DIV_STEPS    = 16;
   localparam int DRW          = 47;

   localparam logic [14:0]          THR_RESET       = 15'd32735;
   localparam logic [15:0]          ONE_F           = 16'h8000;
   localparam logic signed [XW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

   localparam int ATAN_HEAD [11] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575
   };

   typedef struct packed {
      logic [3:0][15:0] a;
      logic [3:0][15:0] b;
      logic [15:0]      t;
      logic             neg;
      logic             lerp;
   } front_type;

   typedef struct packed {
      front_type   f;
      logic [29:0] c30;
   } sq_side_type;

   typedef struct packed {
      logic [3:0][15:0] a;
      logic [3:0][15:0] b;
      logic [15:0]      t;
   } pair_type;

   typedef struct packed {
      logic neg;
      logic lerp;
   } flag_type;

   typedef struct packed {
      logic [3:0][29:0] mag;
      logic [3:0]       neg;
      logic             zero;
   } norm_type;

   // arctangent of 2^-i in Q2.30 radians
   function automatic logic signed [ZW-1:0] atan_val(input int i);
      logic signed [ZW-1:0] v;
      if (i < 11) begin
         v = ZW'(ATAN_HEAD[i]);
      end else begin
         v = ZW'((64'sd1 <<< (QI - i)) - 64'sd1);
      end
      return v;
   endfunction

endpackage

>>> src/qslp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module qslp_isqrt import qslp_pkg::*; #(
   parameter int W  = 62,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [W-1:0]     in_value,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [W/2-1:0]   out_root,
   output logic [SW-1:0]    out_side
);

   localparam int N = W / 2;

   logic          v_ff    [N];
   logic [W-1:0]  rem_ff  [N];
   logic [W:0]    res_ff  [N];
   logic [SW-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [W:0] BIT_K = (W+1)'(1) << (2 * (N - 1 - k));
      logic          v_cur;
      logic [W-1:0]  rem_cur;
      logic [W:0]    res_cur;
      logic [SW-1:0] side_cur;
      logic [W:0]    trial;
      logic          ge;

      if (k == 0) begin : g_head
         assign v_cur    = in_valid;
         assign rem_cur  = in_value;
         assign res_cur  = '0;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = v_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign res_cur  = res_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign trial = res_cur + BIT_K;
      assign ge    = {1'b0, rem_cur} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[k] <= side_cur;
         if (ge) begin
            rem_ff[k] <= rem_cur - trial[W-1:0];
            res_ff[k] <= (res_cur >> 1) + BIT_K;
         end else begin
            rem_ff[k] <= rem_cur;
            res_ff[k] <= res_cur >> 1;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_root  = res_ff[N-1][N-1:0];
   assign out_side  = side_ff[N-1];

endmodule

>>> src/qslp_cordic.sv
// Pipelined CORDIC, vectoring or rotation, one micro-rotation per stage.
module qslp_cordic import qslp_pkg::*; #(
   parameter bit VECTOR = 1'b1,
   parameter int SW     = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic signed [ZW-1:0] in_z,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output logic signed [ZW-1:0] out_z,
   output logic [SW-1:0]        out_side
);

   logic                 v_ff    [CORDIC_STEPS];
   logic signed [XW-1:0] x_ff    [CORDIC_STEPS];
   logic signed [XW-1:0] y_ff    [CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff    [CORDIC_STEPS];
   logic [SW-1:0]        side_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ANG = atan_val(i);
      logic                 v_cur;
      logic signed [XW-1:0] x_cur, y_cur, sx, sy;
      logic signed [ZW-1:0] z_cur, sa;
      logic [SW-1:0]        side_cur;
      logic                 d;

      if (i == 0) begin : g_head
         assign v_cur    = in_valid;
         assign x_cur    = in_x;
         assign y_cur    = in_y;
         assign z_cur    = in_z;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = v_ff[i-1];
         assign x_cur    = x_ff[i-1];
         assign y_cur    = y_ff[i-1];
         assign z_cur    = z_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // vectoring drives y to zero, rotation drives z to zero
      assign d  = VECTOR ? !y_cur[XW-1] : !z_cur[ZW-1];
      assign sx = d ? (y_cur >>> i) : -(y_cur >>> i);
      assign sy = d ? (x_cur >>> i) : -(x_cur >>> i);
      assign sa = d ? ANG : -ANG;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[i] <= side_cur;
         if (VECTOR) begin
            x_ff[i] <= x_cur + sx;
            y_ff[i] <= y_cur - sy;
            z_ff[i] <= z_cur + sa;
         end else begin
            x_ff[i] <= x_cur - sx;
            y_ff[i] <= y_cur + sy;
            z_ff[i] <= z_cur - sa;
         end
      end
   end

   assign out_valid = v_ff[CORDIC_STEPS-1];
   assign out_x     = x_ff[CORDIC_STEPS-1];
   assign out_y     = y_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_side  = side_ff[CORDIC_STEPS-1];

endmodule

>>> src/quaternion_slerp.sv
// Quaternion slerp: fully pipelined, one quaternion pair per clock.
// Raise start with the two quaternions (req_from_*, req_to_*, Q1.15) and the
// blend factor req_blend (Q1.15, values above 1.0 clamp to 1.0). busy is
// always low, so every cycle with start high is a beat.
// Each beat produces one result: rsp_strobe is high for
// exactly one cycle with rsp_out_x/y/z/w holding the normalized quaternion.
// Beats may arrive in every cycle; results then leave in every cycle, in order.
// The pipeline is a chain: dot product, square root of 1-c^2
// (31 stages), CORDIC acos (30), CORDIC sine (30), weighted sum and
// normalization, square root of the sum of squares (31), and a 16-stage
// restoring divider, one register per step.
// csr_we with csr_wdata writes the lerp threshold (Q0.15 cosine); write it
// only while no beat is in flight. Reset loads 0.999 into the threshold and
// empties the pipeline, so beats in flight are lost; with no back-pressure,
// the receiver takes every strobe as it comes.
module quaternion_slerp import qslp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_from_x,
   input  logic signed [15:0] req_from_y,
   input  logic signed [15:0] req_from_z,
   input  logic signed [15:0] req_from_w,
   input  logic signed [15:0] req_to_x,
   input  logic signed [15:0] req_to_y,
   input  logic signed [15:0] req_to_z,
   input  logic signed [15:0] req_to_w,
   input  logic [15:0]        req_blend,
   input  logic               csr_we,
   input  logic [14:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w
);

   localparam logic [61:0] ONE60 = 62'd1 << 60;
   localparam logic [32:0] ONE30 = 33'd1 << 30;

   logic [14:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // stage 1: component products
   logic [3:0][15:0] a_in, b_in;
   logic [15:0]      t_in;
   logic             v1_ff;
   logic [3:0][15:0] a1_ff, b1_ff;
   logic [15:0]      t1_ff;
   logic [3:0][31:0] prod1_ff;

   always_comb begin
      a_in = {req_from_w, req_from_z, req_from_y, req_from_x};
      b_in = {req_to_w, req_to_z, req_to_y, req_to_x};
      t_in = (req_blend > ONE_F) ? ONE_F : req_blend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= a_in;
      b1_ff <= b_in;
      t1_ff <= t_in;
      for (int k = 0; k < 4; k++) begin
         prod1_ff[k] <= $signed(a_in[k]) * $signed(b_in[k]);
      end
   end

   // stage 2: dot product
   logic signed [33:0] dot_in, dot2_ff;
   logic               v2_ff;
   logic [3:0][15:0]   a2_ff, b2_ff;
   logic [15:0]        t2_ff;

   assign dot_in = 34'($signed(prod1_ff[0])) + 34'($signed(prod1_ff[1]))
                 + 34'($signed(prod1_ff[2])) + 34'($signed(prod1_ff[3]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dot2_ff <= dot_in;
      a2_ff   <= a1_ff;
      b2_ff   <= b1_ff;
      t2_ff   <= t1_ff;
   end

   // stage 3: shorter arc and path choice
   logic [32:0] cabs_in;
   logic        neg_in, lerp_in, v3_ff;
   sq_side_type s3_ff;

   always_comb begin
      neg_in  = dot2_ff[33];
      cabs_in = neg_in ? 33'(-dot2_ff) : 33'(dot2_ff);
      lerp_in = !((cabs_in < 33'({thr_ff, 15'd0})) && (cabs_in < ONE30));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff.f.a    <= a2_ff;
      s3_ff.f.b    <= b2_ff;
      s3_ff.f.t    <= t2_ff;
      s3_ff.f.neg  <= neg_in;
      s3_ff.f.lerp <= lerp_in;
      s3_ff.c30    <= cabs_in[29:0];
   end

   // stages 4 and 5: 1 - c^2
   logic        v4_ff, v5_ff;
   logic [59:0] c2_in, c2_ff;
   logic [61:0] sv_ff;
   sq_side_type s4_ff, s5_ff;

   assign c2_in = s3_ff.c30 * s3_ff.c30;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      c2_ff <= c2_in;
      s4_ff <= s3_ff;
      sv_ff <= ONE60 - 62'(c2_ff);
      s5_ff <= s4_ff;
   end

   // sine of the angle, then the angle itself
   logic        sq1_v;
   logic [30:0] sq1_root;
   sq_side_type sq1_side;

   qslp_isqrt #(.W(62), .SW($bits(sq_side_type))) u_sqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_value  (sv_ff),
      .in_side   (s5_ff),
      .out_valid (sq1_v),
      .out_root  (sq1_root),
      .out_side  (sq1_side)
   );

   logic                 acos_v;
   logic signed [ZW-1:0] theta;
   front_type            acos_side;

   qslp_cordic #(.VECTOR(1'b1), .SW($bits(front_type))) u_acos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq1_v),
      .in_x      (XW'(sq1_side.c30)),
      .in_y      (XW'(sq1_root)),
      .in_z      ('0),
      .in_side   (sq1_side.f),
      .out_valid (acos_v),
      .out_x     (),
      .out_y     (),
      .out_z     (theta),
      .out_side  (acos_side)
   );

   // split the angle by t
   logic                 v6_ff, v7_ff;
   logic signed [49:0]   tprod_in, tprod_ff;
   logic signed [ZW-1:0] theta_ff, a1_in, z0_ff, z1_ff;
   front_type            f6_ff, f7_ff;

   assign tprod_in = theta * $signed({1'b0, acos_side.t});
   assign a1_in    = ZW'(tprod_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v6_ff <= acos_v;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      tprod_ff <= tprod_in;
      theta_ff <= theta;
      f6_ff    <= acos_side;
      z0_ff    <= theta_ff - a1_in;
      z1_ff    <= a1_in;
      f7_ff    <= f6_ff;
   end

   logic                 rot0_v, rot1_v;
   logic signed [XW-1:0] sin0, sin1;
   pair_type             rot0_side;
   flag_type             rot1_side;

   qslp_cordic #(.VECTOR(1'b0), .SW($bits(pair_type))) u_sin_from (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_x      (CORDIC_INV_GAIN),
      .in_y      ('0),
      .in_z      (z0_ff),
      .in_side   ({f7_ff.a, f7_ff.b, f7_ff.t}),
      .out_valid (rot0_v),
      .out_x     (),
      .out_y     (sin0),
      .out_z     (),
      .out_side  (rot0_side)
   );

   qslp_cordic #(.VECTOR(1'b0), .SW($bits(flag_type))) u_sin_to (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_x      (CORDIC_INV_GAIN),
      .in_y      ('0),
      .in_z      (z1_ff),
      .in_side   ({f7_ff.neg, f7_ff.lerp}),
      .out_valid (rot1_v),
      .out_x     (),
      .out_y     (sin1),
      .out_z     (),
      .out_side  (rot1_side)
   );

   // weights
   logic signed [XW-1:0] w0_in, w1_in, w0_ff, w1_ff;
   logic                 w_v_ff, w_lerp_ff, w_neg_ff;
   logic [3:0][15:0]     wa_ff, wb_ff;
   logic [16:0]          omt;

   always_comb begin
      omt   = 17'(ONE_F) - 17'(rot0_side.t);
      w0_in = rot1_side.lerp ? XW'({omt, 15'd0}) : sin0;
      w1_in = rot1_side.lerp ? XW'({rot0_side.t, 15'd0}) : sin1;
      if (rot1_side.neg) begin
         w1_in = -w1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff <= 1'b0;
      end else begin
         w_v_ff <= rot0_v;
      end
   end

   always_ff @(posedge clock) begin
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      w_lerp_ff <= rot1_side.lerp;
      w_neg_ff  <= rot1_side.neg;
      wa_ff     <= rot0_side.a;
      wb_ff     <= rot0_side.b;
   end

   // weighted sum
   logic                 p_v_ff, r_v_ff, m_v_ff;
   logic signed [49:0]   pa_ff [4];
   logic signed [49:0]   pb_ff [4];
   logic signed [50:0]   r_ff  [4];
   logic [3:0][MW-1:0]   mag_ff;
   logic [3:0]           rneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
      end else begin
         p_v_ff <= w_v_ff;
         r_v_ff <= p_v_ff;
         m_v_ff <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pa_ff[k]   <= $signed(wa_ff[k]) * w0_ff;
         pb_ff[k]   <= $signed(wb_ff[k]) * w1_ff;
         r_ff[k]    <= 51'(pa_ff[k]) + 51'(pb_ff[k]);
         rneg_ff[k] <= r_ff[k][50];
         mag_ff[k]  <= r_ff[k][50] ? MW'(-r_ff[k]) : MW'(r_ff[k]);
      end
   end

   // largest magnitude and its leading one
   logic               x1_v_ff, x2_v_ff, x3_v_ff;
   logic [MW-1:0]      pmax_ff [2];
   logic [MW-1:0]      m_ff;
   logic [3:0][MW-1:0] mag1_ff, mag2_ff, mag3_ff;
   logic [3:0]         rneg1_ff, rneg2_ff, rneg3_ff;
   logic               zero2_ff, zero3_ff;
   logic [5:0]         pos_in, pos_ff;

   always_comb begin
      pos_in = '0;
      for (int j = 0; j < MW; j++) begin
         if (m_ff[j]) begin
            pos_in = 6'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_v_ff <= 1'b0;
         x2_v_ff <= 1'b0;
         x3_v_ff <= 1'b0;
      end else begin
         x1_v_ff <= m_v_ff;
         x2_v_ff <= x1_v_ff;
         x3_v_ff <= x2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      pmax_ff[0] <= (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      pmax_ff[1] <= (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
      mag1_ff    <= mag_ff;
      rneg1_ff   <= rneg_ff;
      m_ff       <= (pmax_ff[0] > pmax_ff[1]) ? pmax_ff[0] : pmax_ff[1];
      mag2_ff    <= mag1_ff;
      rneg2_ff   <= rneg1_ff;
      zero2_ff   <= (pmax_ff[0] == '0) && (pmax_ff[1] == '0);
      pos_ff     <= pos_in;
      mag3_ff    <= mag2_ff;
      rneg3_ff   <= rneg2_ff;
      zero3_ff   <= zero2_ff;
   end

   // bring the largest magnitude into [2^29, 2^30), then sum of squares
   logic        n_v_ff, q_v_ff, s_v_ff, n2_v_ff;
   norm_type    norm_in, norm_ff, norm1_ff, norm2_ff, norm3_ff;
   logic [59:0] sq_ff [4];
   logic [60:0] ps_ff [2];
   logic [61:0] n2_ff;

   always_comb begin
      norm_in.neg  = rneg3_ff;
      norm_in.zero = zero3_ff;
      for (int k = 0; k < 4; k++) begin
         if (pos_ff >= 6'd29) begin
            norm_in.mag[k] = 30'(mag3_ff[k] >> (pos_ff - 6'd29));
         end else begin
            norm_in.mag[k] = 30'(mag3_ff[k] << (6'd29 - pos_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff  <= 1'b0;
         q_v_ff  <= 1'b0;
         s_v_ff  <= 1'b0;
         n2_v_ff <= 1'b0;
      end else begin
         n_v_ff  <= x3_v_ff;
         q_v_ff  <= n_v_ff;
         s_v_ff  <= q_v_ff;
         n2_v_ff <= s_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      for (int k = 0; k < 4; k++) begin
         sq_ff[k] <= norm_ff.mag[k] * norm_ff.mag[k];
      end
      norm1_ff <= norm_ff;
      ps_ff[0] <= 61'(sq_ff[0]) + 61'(sq_ff[1]);
      ps_ff[1] <= 61'(sq_ff[2]) + 61'(sq_ff[3]);
      norm2_ff <= norm1_ff;
      n2_ff    <= 62'(ps_ff[0]) + 62'(ps_ff[1]);
      norm3_ff <= norm2_ff;
   end

   logic        sq2_v;
   logic [30:0] len;
   norm_type    sq2_side;

   qslp_isqrt #(.W(62), .SW($bits(norm_type))) u_sqrt_len (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n2_v_ff),
      .in_value  (n2_ff),
      .in_side   (norm3_ff),
      .out_valid (sq2_v),
      .out_root  (len),
      .out_side  (sq2_side)
   );

   // rounded numerator for the divider
   logic           num_v_ff;
   logic [DRW-1:0] num_ff [4];
   logic [30:0]    num_len_ff;
   logic [3:0]     num_neg_ff;
   logic           num_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_v_ff <= 1'b0;
      end else begin
         num_v_ff <= sq2_v;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         num_ff[k] <= DRW'({sq2_side.mag[k], 15'd0}) + DRW'(len >> 1);
      end
      num_len_ff  <= len;
      num_neg_ff  <= sq2_side.neg;
      num_zero_ff <= sq2_side.zero;
   end

   // restoring divider, one quotient bit per stage
   logic           div_v_ff    [DIV_STEPS];
   logic [DRW-1:0] div_rem_ff  [DIV_STEPS][4];
   logic [15:0]    div_q_ff    [DIV_STEPS][4];
   logic [30:0]    div_len_ff  [DIV_STEPS];
   logic [3:0]     div_neg_ff  [DIV_STEPS];
   logic           div_zero_ff [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int SH = DIV_STEPS - 1 - j;
      logic           v_cur, zero_cur;
      logic [DRW-1:0] rem_cur [4];
      logic [15:0]    q_cur   [4];
      logic [30:0]    len_cur;
      logic [3:0]     neg_cur;
      logic [DRW-1:0] dvs;

      if (j == 0) begin : g_head
         always_comb begin
            for (int k = 0; k < 4; k++) begin
               rem_cur[k] = num_ff[k];
               q_cur[k]   = '0;
            end
         end
         assign v_cur    = num_v_ff;
         assign len_cur  = num_len_ff;
         assign neg_cur  = num_neg_ff;
         assign zero_cur = num_zero_ff;
      end else begin : g_body
         always_comb begin
            for (int k = 0; k < 4; k++) begin
               rem_cur[k] = div_rem_ff[j-1][k];
               q_cur[k]   = div_q_ff[j-1][k];
            end
         end
         assign v_cur    = div_v_ff[j-1];
         assign len_cur  = div_len_ff[j-1];
         assign neg_cur  = div_neg_ff[j-1];
         assign zero_cur = div_zero_ff[j-1];
      end

      assign dvs = DRW'(len_cur) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[j] <= 1'b0;
         end else begin
            div_v_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         div_len_ff[j]  <= len_cur;
         div_neg_ff[j]  <= neg_cur;
         div_zero_ff[j] <= zero_cur;
         for (int k = 0; k < 4; k++) begin
            if (rem_cur[k] >= dvs) begin
               div_rem_ff[j][k] <= rem_cur[k] - dvs;
               div_q_ff[j][k]   <= q_cur[k] | (16'd1 << SH);
            end else begin
               div_rem_ff[j][k] <= rem_cur[k];
               div_q_ff[j][k]   <= q_cur[k];
            end
         end
      end
   end

   // saturate, apply sign, drive the result beat
   logic             rsp_strobe_ff;
   logic [3:0][15:0] out_in, out_ff;
   logic [15:0]      qs;

   always_comb begin
      out_in = '0;
      qs     = '0;
      for (int k = 0; k < 4; k++) begin
         qs = div_q_ff[DIV_STEPS-1][k];
         if (div_zero_ff[DIV_STEPS-1]) begin
            out_in[k] = '0;
         end else if (div_neg_ff[DIV_STEPS-1][k]) begin
            if (qs > 16'd32768) begin
               qs = 16'd32768;
            end
            out_in[k] = 16'd0 - qs;
         end else begin
            if (qs > 16'd32767) begin
               qs = 16'd32767;
            end
            out_in[k] = qs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_v_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_out_x  = out_ff[0];
   assign rsp_out_y  = out_ff[1];
   assign rsp_out_z  = out_ff[2];
   assign rsp_out_w  = out_ff[3];

   a_rot_lockstep: assert property (@(posedge clock) disable iff (reset)
      rot0_v == rot1_v)
      else $error("sine units out of step");

   a_lerp_weights: assert property (@(posedge clock) disable iff (reset)
      (w_v_ff && w_lerp_ff) |->
         (w0_ff + (w_neg_ff ? -w1_ff : w1_ff)) == (XW'(1) <<< QI))
      else $error("lerp weights do not sum to one");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (n_v_ff && !norm_ff.zero) |->
         (norm_ff.mag[0][29] || norm_ff.mag[1][29] ||
          norm_ff.mag[2][29] || norm_ff.mag[3][29]))
      else $error("largest magnitude not normalized");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (div_v_ff[DIV_STEPS-1] && !div_zero_ff[DIV_STEPS-1]) |->
         (div_q_ff[DIV_STEPS-1][0] <= 16'd32768 && div_q_ff[DIV_STEPS-1][1] <= 16'd32768 &&
          div_q_ff[DIV_STEPS-1][2] <= 16'd32768 && div_q_ff[DIV_STEPS-1][3] <= 16'd32768))
      else $error("quotient above unit length");

endmodule
